[sv/sbdd_pkg.sv]
package sbdd_pkg;

	localparam int VALUE_WIDTH = 128;
	localparam int IN_WIDTH = 64;
	localparam int DIGIT_WIDTH = 4;
	localparam int NUM_DIGITS = ((VALUE_WIDTH * 1233) >> 12) + 1;
	localparam int BCD_WIDTH = DIGIT_WIDTH * NUM_DIGITS;
	localparam int CNT_WIDTH = $clog2(VALUE_WIDTH + 1);
	localparam int LEFT_WIDTH = $clog2(NUM_DIGITS + 1);

	typedef logic [VALUE_WIDTH-1:0] value_t;
	typedef logic [BCD_WIDTH-1:0] bcd_t;
	typedef logic [DIGIT_WIDTH-1:0] digit_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONVERT,
		ST_SKIP,
		ST_EMIT
	} state_t;

endpackage

[sv/sbdd_in_if.sv]
interface sbdd_in_if;
	logic valid;
	logic ready;
	logic [sbdd_pkg::IN_WIDTH-1:0] value_high;
	logic [sbdd_pkg::IN_WIDTH-1:0] value_low;

	modport source (output valid, output value_high, output value_low, input ready);
	modport sink (input valid, input value_high, input value_low, output ready);
endinterface

[sv/sbdd_out_if.sv]
interface sbdd_out_if;
	logic valid;
	logic ready;
	sbdd_pkg::digit_t digit;
	logic negative;
	logic last;

	modport source (output valid, output digit, output negative, output last, input ready);
	modport sink (input valid, input digit, input negative, input last, output ready);
endinterface

[sv/sbdd_dabble.sv]
module sbdd_dabble (
	input  sbdd_pkg::bcd_t bcd,
	input  logic           shift_bit,
	output sbdd_pkg::bcd_t bcd_next
);

	sbdd_pkg::bcd_t adj;

	// Every digit of five or more gets three added so that the shift carries into the next digit.
	always_comb begin
		for (int i = 0; i < sbdd_pkg::NUM_DIGITS; i++) begin
			if (bcd[i*sbdd_pkg::DIGIT_WIDTH +: sbdd_pkg::DIGIT_WIDTH] >= 4'd5) begin
				adj[i*sbdd_pkg::DIGIT_WIDTH +: sbdd_pkg::DIGIT_WIDTH] =
					bcd[i*sbdd_pkg::DIGIT_WIDTH +: sbdd_pkg::DIGIT_WIDTH] + 4'd3;
			end else begin
				adj[i*sbdd_pkg::DIGIT_WIDTH +: sbdd_pkg::DIGIT_WIDTH] =
					bcd[i*sbdd_pkg::DIGIT_WIDTH +: sbdd_pkg::DIGIT_WIDTH];
			end
		end
	end

	assign bcd_next = {adj[sbdd_pkg::BCD_WIDTH-2:0], shift_bit};

endmodule

[sv/signed_binary_to_decimal_digits_unit.sv]
// Converts one two's complement integer into its decimal digits.
//
// The input channel carries one item as value_high and value_low; the low
// VALUE_WIDTH bits of {value_high, value_low} hold the value and its top bit
// is the sign. The output channel returns one item per decimal digit of the
// magnitude, most significant first, with no leading zeros. Every digit
// carries negative, and the least significant one carries last. Zero gives
// the single digit 0.
//
// After an item is accepted the block runs the shift-and-correct loop, one
// input bit per cycle through a single correction unit, then drops the
// leading zero digits one at a time and settles on the first digit, then
// delivers the digits one at a time. The next item is accepted only after
// the last digit is taken. Input ready is high only while no item is in
// progress.
//
// Reset clears the sequencer, so the block comes up idle with no valid
// output. A stalled receiver holds the current digit steady on the output
// until it is taken; nothing is lost and no new item is accepted meanwhile.
module signed_binary_to_decimal_digits_unit (
	input  logic              clk,
	input  logic              arst_n,
	sbdd_in_if.sink           in,
	sbdd_out_if.source        out
);

	sbdd_pkg::state_t state_q, state_d;
	logic [sbdd_pkg::CNT_WIDTH-1:0]  cnt_q, cnt_d;
	logic [sbdd_pkg::LEFT_WIDTH-1:0] left_q, left_d;
	sbdd_pkg::value_t bin_q, bin_d;
	sbdd_pkg::bcd_t   bcd_q, bcd_d;
	logic             neg_q, neg_d;

	sbdd_pkg::value_t word;
	sbdd_pkg::bcd_t   bcd_step;
	sbdd_pkg::digit_t top_digit;
	logic             last_digit;

	assign word = sbdd_pkg::value_t'({in.value_high, in.value_low});
	assign top_digit = bcd_q[sbdd_pkg::BCD_WIDTH-1 -: sbdd_pkg::DIGIT_WIDTH];
	assign last_digit = (left_q == sbdd_pkg::LEFT_WIDTH'(1));

	sbdd_dabble u_dabble (
		.bcd       (bcd_q),
		.shift_bit (bin_q[sbdd_pkg::VALUE_WIDTH-1]),
		.bcd_next  (bcd_step)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbdd_pkg::ST_IDLE;
			cnt_q   <= '0;
			left_q  <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			left_q  <= left_d;
		end
	end

	always_ff @(posedge clk) begin
		bin_q <= bin_d;
		bcd_q <= bcd_d;
		neg_q <= neg_d;
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		left_d    = left_q;
		bin_d     = bin_q;
		bcd_d     = bcd_q;
		neg_d     = neg_q;
		in.ready  = 1'b0;
		out.valid = 1'b0;
		case (state_q)
			sbdd_pkg::ST_IDLE: begin
				in.ready = 1'b1;
				if (in.valid) begin
					neg_d   = word[sbdd_pkg::VALUE_WIDTH-1];
					bin_d   = word[sbdd_pkg::VALUE_WIDTH-1] ? (~word + 1'b1) : word;
					bcd_d   = '0;
					cnt_d   = sbdd_pkg::CNT_WIDTH'(sbdd_pkg::VALUE_WIDTH);
					state_d = sbdd_pkg::ST_CONVERT;
				end
			end
			sbdd_pkg::ST_CONVERT: begin
				bcd_d = bcd_step;
				bin_d = {bin_q[sbdd_pkg::VALUE_WIDTH-2:0], 1'b0};
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == sbdd_pkg::CNT_WIDTH'(1)) begin
					left_d  = sbdd_pkg::LEFT_WIDTH'(sbdd_pkg::NUM_DIGITS);
					state_d = sbdd_pkg::ST_SKIP;
				end
			end
			sbdd_pkg::ST_SKIP: begin
				if (top_digit == '0 && !last_digit) begin
					bcd_d  = {bcd_q[sbdd_pkg::BCD_WIDTH-sbdd_pkg::DIGIT_WIDTH-1:0],
						sbdd_pkg::DIGIT_WIDTH'(0)};
					left_d = left_q - 1'b1;
				end else begin
					state_d = sbdd_pkg::ST_EMIT;
				end
			end
			sbdd_pkg::ST_EMIT: begin
				out.valid = 1'b1;
				if (out.ready) begin
					if (last_digit) begin
						state_d = sbdd_pkg::ST_IDLE;
					end else begin
						bcd_d  = {bcd_q[sbdd_pkg::BCD_WIDTH-sbdd_pkg::DIGIT_WIDTH-1:0],
							sbdd_pkg::DIGIT_WIDTH'(0)};
						left_d = left_q - 1'b1;
					end
				end
			end
			default: begin
				state_d = sbdd_pkg::ST_IDLE;
			end
		endcase
	end

	assign out.digit    = top_digit;
	assign out.negative = neg_q;
	assign out.last     = last_digit;

	a_digit_decimal: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid |-> out.digit <= 4'd9)
		else $error("digit out of decimal range");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && out.ready && !out.last |=> out.valid)
		else $error("digit run broken before last");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && out.ready && out.last |=> in.ready && !out.valid)
		else $error("block not idle after last digit");

	a_no_early_digit: assert property (@(posedge clk) disable iff (!arst_n)
		in.valid && in.ready |=> !out.valid && !in.ready)
		else $error("digit shown before conversion");

endmodule

[tb/sv/digit_stream_checker.sv]
module digit_stream_checker (
	input  logic clk,
	input  logic arst_n,
	sbdd_in_if   in_ch,
	sbdd_out_if  out_ch,
	output int   errors,
	output int   pending,
	output int   values_seen,
	output int   negatives_seen,
	output int   digits_seen,
	output int   longest_run
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [2*sbdd_pkg::IN_WIDTH-1:0] word_t;

	typedef struct packed {
		sbdd_pkg::digit_t digit;
		logic             negative;
		logic             last;
	} digit_item_t;

	digit_item_t expected_digits[$];
	int fail_count;
	int value_count;
	int negative_count;
	int digit_count;
	int longest;

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		fail_count++;
	endtask

	// The value lives in the low VALUE_WIDTH bits of the word. Negative values
	// are converted through their two's complement magnitude.
	function automatic void predict_digits(input word_t word);
		sbdd_pkg::value_t val;
		sbdd_pkg::value_t mag;
		logic             neg;
		sbdd_pkg::digit_t msd_first[$];
		digit_item_t      item;
		val = word[sbdd_pkg::VALUE_WIDTH-1:0];
		neg = val[sbdd_pkg::VALUE_WIDTH-1];
		mag = neg ? -val : val;
		do begin
			msd_first.push_front(sbdd_pkg::digit_t'(mag % 10));
			mag = mag / 10;
		end while (mag != 0);
		foreach (msd_first[k]) begin
			item.digit = msd_first[k];
			item.negative = neg;
			item.last = (k == msd_first.size() - 1);
			expected_digits.push_back(item);
		end
		value_count++;
		if (neg) begin
			negative_count++;
		end
		if (msd_first.size() > longest) begin
			longest = msd_first.size();
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		digit_item_t want;
		if (!arst_n) begin
			expected_digits.delete();
			fail_count = 0;
			value_count = 0;
			negative_count = 0;
			digit_count = 0;
			longest = 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				predict_digits({in_ch.value_high, in_ch.value_low});
			end
			if (out_ch.valid && out_ch.ready) begin
				digit_count++;
				if (expected_digits.size() == 0) begin
					report_mismatch($sformatf("digit %0d arrived with nothing expected",
						out_ch.digit));
				end else begin
					want = expected_digits.pop_front();
					if (out_ch.digit !== want.digit) begin
						report_mismatch($sformatf("digit %0d, expected %0d",
							out_ch.digit, want.digit));
					end
					if (out_ch.negative !== want.negative) begin
						report_mismatch($sformatf("negative %b, expected %b",
							out_ch.negative, want.negative));
					end
					if (out_ch.last !== want.last) begin
						report_mismatch($sformatf("last %b, expected %b",
							out_ch.last, want.last));
					end
				end
			end
		end
		errors <= fail_count;
		pending <= expected_digits.size();
		values_seen <= value_count;
		negatives_seen <= negative_count;
		digits_seen <= digit_count;
		longest_run <= longest;
	end

endmodule

[tb/sv/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [2*sbdd_pkg::IN_WIDTH-1:0] word_t;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 200;
	localparam int RANDOM_PER_PHASE = 60;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	int   cycle_count = 0;
	word_t pow10 [0:38];

	int errors;
	int pending;
	int values_seen;
	int negatives_seen;
	int digits_seen;
	int longest_run;

	sbdd_in_if  in_ch ();
	sbdd_out_if out_ch ();

	signed_binary_to_decimal_digits_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (in_ch),
		.out    (out_ch)
	);

	digit_stream_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_ch          (in_ch),
		.out_ch         (out_ch),
		.errors         (errors),
		.pending        (pending),
		.values_seen    (values_seen),
		.negatives_seen (negatives_seen),
		.digits_seen    (digits_seen),
		.longest_run    (longest_run)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		out_ch.ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d digits outstanding.",
				cycle_count, pending);
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_value(input word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.value_high <= w[2*sbdd_pkg::IN_WIDTH-1:sbdd_pkg::IN_WIDTH];
		in_ch.value_low <= w[sbdd_pkg::IN_WIDTH-1:0];
		@(posedge clk);
		while (!in_ch.ready) begin
			@(posedge clk);
		end
	endtask

	// Mixes full-range words with short magnitudes and values next to
	// powers of ten, where the digit count changes.
	function automatic word_t random_word();
		word_t w;
		w = {$urandom, $urandom, $urandom, $urandom};
		case ($urandom_range(3))
			0: begin
			end
			1: begin
				w = w >> $urandom_range(127);
				if ($urandom_range(1)) w = -w;
			end
			2: begin
				w = pow10[$urandom_range(38)] + word_t'($urandom_range(2)) - word_t'(1);
				if ($urandom_range(1)) w = -w;
			end
			default: begin
				w = word_t'($urandom_range(100));
				if ($urandom_range(1)) w = -w;
			end
		endcase
		return w;
	endfunction

	initial begin
		int phase;
		in_ch.valid <= 1'b0;
		in_ch.value_high <= '0;
		in_ch.value_low <= '0;
		pow10[0] = word_t'(1);
		for (int k = 1; k <= 38; k++) begin
			pow10[k] = pow10[k-1] * word_t'(10);
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 11;
					recv_stall_pct = 82;
				end
				1: begin
					send_idle_pct = 82;
					recv_stall_pct = 11;
				end
				default: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			if (phase == 0) begin
				send_value('0);
				send_value(word_t'(1));
				send_value(word_t'(9));
				send_value(word_t'(10));
				send_value('1);
				send_value(-word_t'(9));
				send_value(-word_t'(10));
				send_value({1'b0, {(2*sbdd_pkg::IN_WIDTH-1){1'b1}}});
				send_value({1'b1, {(2*sbdd_pkg::IN_WIDTH-1){1'b0}}});
				send_value({1'b1, {(2*sbdd_pkg::IN_WIDTH-2){1'b0}}, 1'b1});
				send_value({{sbdd_pkg::IN_WIDTH{1'b0}}, {sbdd_pkg::IN_WIDTH{1'b1}}});
				send_value({{sbdd_pkg::IN_WIDTH{1'b1}}, {sbdd_pkg::IN_WIDTH{1'b0}}});
				send_value({{(sbdd_pkg::IN_WIDTH-1){1'b0}}, 1'b1, {sbdd_pkg::IN_WIDTH{1'b0}}});
				send_value({{sbdd_pkg::IN_WIDTH{1'b0}}, 1'b1, {(sbdd_pkg::IN_WIDTH-1){1'b0}}});
				send_value(pow10[38]);
				send_value(pow10[38] - word_t'(1));
				send_value(-pow10[38]);
				send_value(-pow10[19]);
				send_value({(sbdd_pkg::IN_WIDTH){2'b10}});
				send_value({(sbdd_pkg::IN_WIDTH){2'b01}});
			end
			repeat (RANDOM_PER_PHASE) begin
				send_value(random_word());
			end
		end
		in_ch.valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Converted %0d values, %0d of them negative, checking %0d digits.",
			values_seen, negatives_seen, digits_seen);
		$display("Longest digit run was %0d; stall-heavy, idle-heavy and full-rate pacing ran.",
			longest_run);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
